// ===== hdl/pidx_pkg.sv =====
// Shared types, constants and color expansion tables for the palette indexer.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package pidx_pkg;

  // Palette geometry.
  localparam int PaletteEntries = 256;
  localparam int IdxW           = $clog2(PaletteEntries);
  localparam int CntW           = $clog2(PaletteEntries + 1);

  // Field widths on the streams.
  localparam int KeyW     = 24;
  localparam int PixelW   = 32;
  localparam int OutIdxW  = 8;
  localparam int OutCntW  = 9;
  localparam int OutDataW = 48;

  // Register map. Registers sit at 4-byte steps, selected by paddr[2].
  localparam int AddrW = 3;
  localparam logic RegPixelFormat = 1'b0;

  // Pixel format codes.
  typedef enum logic {
    FMT_XRGB32 = 1'b0,
    FMT_RGB565 = 1'b1
  } pix_fmt_e;

  // Channel maxima of the RGB565 format and of an 8-bit channel.
  localparam int Ch5Max  = 31;
  localparam int Ch6Max  = 63;
  localparam int ChanMax = 255;

  typedef logic [7:0] exp5_lut_t [32];
  typedef logic [7:0] exp6_lut_t [64];

  // Expansion of a 5-bit channel to 8 bits, c*255/31 truncated.
  function automatic exp5_lut_t build_exp5();
    exp5_lut_t lut;
    for (int i = 0; i < 32; i++) begin
      lut[i] = 8'((i * ChanMax) / Ch5Max);
    end
    return lut;
  endfunction

  // Expansion of a 6-bit channel to 8 bits, c*255/63 truncated.
  function automatic exp6_lut_t build_exp6();
    exp6_lut_t lut;
    for (int i = 0; i < 64; i++) begin
      lut[i] = 8'((i * ChanMax) / Ch6Max);
    end
    return lut;
  endfunction

  localparam exp5_lut_t Exp5Lut = build_exp5();
  localparam exp6_lut_t Exp6Lut = build_exp6();

  // Lookup request into the palette.
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            last;
  } cam_req_t;

  // Lookup response for the request at hand.
  typedef struct packed {
    logic [IdxW-1:0] index;
    logic            is_new;
    logic            ovf;
    logic [CntW-1:0] count;
  } cam_rsp_t;

  // Current palette status.
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            ovf;
  } cam_state_t;

endpackage

`default_nettype wire

// ===== hdl/pidx_key_expand.sv =====
// Converts a raw pixel word into a 24-bit RGB key.
// Depends on pidx_pkg for widths, format codes and expansion tables.
`timescale 1ns / 1ps
`default_nettype none

module pidx_key_expand (
  input  var pidx_pkg::pix_fmt_e        fmt_i,
  input  var logic [pidx_pkg::PixelW-1:0] pixel_i,
  output var logic [pidx_pkg::KeyW-1:0]   key_o
);

  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  // RGB565 channels through the expansion tables.
  always_comb begin
    red   = pidx_pkg::Exp5Lut[pixel_i[15:11]];
    green = pidx_pkg::Exp6Lut[pixel_i[10:5]];
    blue  = pidx_pkg::Exp5Lut[pixel_i[4:0]];
  end

  // Select the key by format; unused upper bits are dropped.
  always_comb begin
    case (fmt_i)
      pidx_pkg::FMT_RGB565: key_o = {red, green, blue};
      pidx_pkg::FMT_XRGB32: key_o = pixel_i[pidx_pkg::KeyW-1:0];
      default:              key_o = pixel_i[pidx_pkg::KeyW-1:0];
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pidx_palette_cam.sv =====
// Palette store with parallel match, entry count and sticky overflow flag.
// Depends on pidx_pkg for palette geometry and the request/response structs.
`timescale 1ns / 1ps
`default_nettype none

module pidx_palette_cam (
  input  var logic                 clk_i,
  input  var logic                 rst_ni,
  input  var logic                 req_valid_i,
  input  var pidx_pkg::cam_req_t   req_i,
  output var pidx_pkg::cam_rsp_t   rsp_o,
  output var pidx_pkg::cam_state_t state_o
);

  localparam int N = pidx_pkg::PaletteEntries;

  logic [pidx_pkg::KeyW-1:0] store_q [N];
  logic [pidx_pkg::CntW-1:0] count_q, count_d;
  logic                      ovf_q, ovf_d;
  logic [N-1:0]              hit;
  logic                      any_hit;
  logic [pidx_pkg::IdxW-1:0] hit_idx;
  logic                      wr_en;
  logic [pidx_pkg::IdxW-1:0] wr_idx;

  // One comparator per entry; only entries below the count take part.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit[i] = (pidx_pkg::CntW'(i) < count_q) && (store_q[i] == req_i.key);
    end
  end

  // Stored keys are distinct, so at most one entry hits and an OR encodes it.
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      hit_idx = hit_idx | (hit[i] ? pidx_pkg::IdxW'(i) : '0);
    end
    any_hit = |hit;
  end

  assign wr_idx = count_q[pidx_pkg::IdxW-1:0];

  // Hit, append or overflow decision and next state.
  always_comb begin
    rsp_o.index  = '0;
    rsp_o.is_new = 1'b0;
    rsp_o.ovf    = ovf_q;
    rsp_o.count  = count_q;
    wr_en        = 1'b0;
    if (!ovf_q) begin
      if (any_hit) begin
        rsp_o.index = hit_idx;
      end else if (count_q < pidx_pkg::CntW'(N)) begin
        rsp_o.index  = wr_idx;
        rsp_o.is_new = 1'b1;
        rsp_o.count  = count_q + 1'b1;
        wr_en        = req_valid_i;
      end else begin
        rsp_o.ovf = 1'b1;
      end
    end
    count_d = count_q;
    ovf_d   = ovf_q;
    if (req_valid_i) begin
      if (req_i.last) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = rsp_o.count;
        ovf_d   = rsp_o.ovf;
      end
    end
  end

  // Palette entries: written once each per frame, no reset needed.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= req_i.key;
    end
  end

  // Count and overflow state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign state_o.count = count_q;
  assign state_o.ovf   = ovf_q;

endmodule

`default_nettype wire

// ===== hdl/palette_indexer.sv =====
// Top level of the palette indexer: stream ports, APB register, pipeline control.
// Depends on pidx_pkg, pidx_key_expand and pidx_palette_cam.
`timescale 1ns / 1ps
`default_nettype none

//  Port group  | Direction | Carries
//  s_axis_*    | in        | one pixel per request, tlast ends the frame
//  m_axis_*    | out       | one result per pixel, tlast echoes frame end
//  APB         | in/out    | pixel_format register at byte address 0
//
// One pixel per cycle sustained while the output is not stalled. The key is
// registered on input, matched against all palette entries from the input
// register and the result registered; the parallel match sets the rate.
// Reset clears the entry count, overflow flag and pixel_format; the palette
// store has no reset, only entries below the count are ever compared.
// A stalled output holds its result and the input stage keeps one pixel.

module palette_indexer (
  input  var logic                            clk_i,
  input  var logic                            rst_ni,
  // Input stream
  input  var logic                            s_axis_tvalid,
  output var logic                            s_axis_tready,
  input  var logic [pidx_pkg::PixelW-1:0]     s_axis_tdata,  // pixel_word[31:0]
  input  var logic                            s_axis_tlast,
  // Output stream
  output var logic                            m_axis_tvalid,
  input  var logic                            m_axis_tready,
  // color_index[7:0], is_new[8], color_rgb[32:9], overflowed[33],
  // color_count[42:34], zero fill[47:43]
  output var logic [pidx_pkg::OutDataW-1:0]   m_axis_tdata,
  output var logic                            m_axis_tlast,
  // Configuration
  input  var logic                            psel,
  input  var logic                            penable,
  input  var logic                            pwrite,
  input  var logic [pidx_pkg::AddrW-1:0]      paddr,
  input  var logic [31:0]                     pwdata,
  output var logic [31:0]                     prdata,
  output var logic                            pready
);

  pidx_pkg::pix_fmt_e        fmt_q;
  logic [pidx_pkg::KeyW-1:0] key_in;
  logic [pidx_pkg::KeyW-1:0] s1_key_q;
  logic                      s1_last_q;
  logic                      s1_valid_q;
  logic                      advance;
  pidx_pkg::cam_req_t        cam_req;
  pidx_pkg::cam_rsp_t        cam_rsp;
  pidx_pkg::cam_state_t      cam_state;
  logic                      res_valid_q;
  logic [pidx_pkg::OutIdxW-1:0] res_index_q;
  logic                      res_new_q;
  logic [pidx_pkg::KeyW-1:0] res_key_q;
  logic                      res_ovf_q;
  logic [pidx_pkg::OutCntW-1:0] res_count_q;
  logic                      res_last_q;
  logic                      reg_sel;

  // Configuration register, written on the access phase.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == pidx_pkg::RegPixelFormat);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= pidx_pkg::FMT_XRGB32;
    end else if (psel && penable && pwrite && reg_sel) begin
      fmt_q <= pidx_pkg::pix_fmt_e'(pwdata[0]);
    end
  end

  assign prdata = reg_sel ? {31'd0, fmt_q} : 32'd0;

  // Key formation ahead of the input register.
  pidx_key_expand u_key (
    .fmt_i   (fmt_q),
    .pixel_i (s_axis_tdata),
    .key_o   (key_in)
  );

  // Pipeline handshake: stage one moves on when the result slot frees up.
  assign advance       = s1_valid_q && (!res_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Input payload register.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_key_q  <= key_in;
      s1_last_q <= s_axis_tlast;
    end
  end

  // Palette lookup and update for the pixel in stage one.
  assign cam_req.key  = s1_key_q;
  assign cam_req.last = s1_last_q;

  pidx_palette_cam u_cam (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (advance),
    .req_i       (cam_req),
    .rsp_o       (cam_rsp),
    .state_o     (cam_state)
  );

  // Result register.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_index_q <= pidx_pkg::OutIdxW'(cam_rsp.index);
      res_new_q   <= cam_rsp.is_new;
      res_key_q   <= s1_key_q;
      res_ovf_q   <= cam_rsp.ovf;
      res_count_q <= pidx_pkg::OutCntW'(cam_rsp.count);
      res_last_q  <= s1_last_q;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {5'd0, res_count_q, res_ovf_q, res_key_q, res_new_q, res_index_q};
  assign m_axis_tlast  = res_last_q;

  // A new entry always lands at the top of the palette.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_new_q) |->
      (res_count_q == (pidx_pkg::OutCntW'(res_index_q) + 1'b1)))
    else $error("new entry index does not match color count");

  // An overflowed pixel reports index zero and no new entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_ovf_q) |-> (res_index_q == '0 && !res_new_q))
    else $error("overflowed pixel carries an index or new entry");

  // The end of a frame clears the palette state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && s1_last_q) |=> (cam_state.count == '0 && !cam_state.ovf))
    else $error("palette state not cleared after frame end");

  // The entry count never exceeds the palette size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cam_state.count <= pidx_pkg::CntW'(pidx_pkg::PaletteEntries))
    else $error("palette entry count out of range");

endmodule

`default_nettype wire
